>>> rtl/g2u_pkg.sv
// shared types and constants of the gb2312 to utf-8 converter
`timescale 1ns / 1ps
`default_nettype none
package g2u_pkg;

  localparam int DEF_TABLE_DEPTH = 8192;

  // field widths
  localparam int IDX_W   = 13;
  localparam int CODE_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 17;
  localparam int MAXL_W  = 16;
  localparam int NENT_W  = 14;
  localparam int CFG_W   = 16;
  localparam int ENTRY_W = 2 * CODE_W;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // register indexes
  localparam logic REG_MAX_LEN     = 1'b0;
  localparam logic REG_TABLE_ENTRIES = 1'b1;

  localparam logic [MAXL_W-1:0] MAX_LEN_RST = 16'hFFFF;

  // utf-8 packing
  localparam logic [BYTE_W-1:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [BYTE_W-1:0] UTF8_CONT  = 8'h80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } g2u_state_t;

  typedef struct packed {
    logic load_entry;
    logic stage_term;
    logic stage_ascii;
    logic hold_lead;
    logic start_search;
    logic search_step;
    logic stage_char;
    logic push;
  } g2u_cmd_t;

  typedef struct packed {
    logic op_text;
    logic byte_zero;
    logic byte_high;
    logic lead_held;
    logic at_limit;
    logic range_empty;
    logic key_hit;
    logic out_free;
    logic stage_last;
  } g2u_sts_t;

endpackage
`default_nettype wire

>>> rtl/g2u_ctrl.sv
// controller state machine of the gb2312 to utf-8 converter
`timescale 1ns / 1ps
`default_nettype none
module g2u_ctrl
  import g2u_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire g2u_sts_t sts,
  output g2u_cmd_t      cmd
);

  g2u_state_t state_r;
  g2u_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority if (!sts.op_text) begin
            cmd.load_entry = 1'b1;
          end else if (sts.byte_zero) begin
            cmd.stage_term = 1'b1;
            state_nxt      = ST_EMIT;
          end else if (sts.lead_held) begin
            cmd.start_search = 1'b1;
            state_nxt        = ST_SEARCH;
          end else if (sts.at_limit) begin
            // byte dropped
          end else if (sts.byte_high) begin
            cmd.hold_lead = 1'b1;
          end else begin
            cmd.stage_ascii = 1'b1;
            state_nxt       = ST_EMIT;
          end
        end
      end
      ST_SEARCH: begin
        priority if (sts.range_empty) begin
          state_nxt = ST_IDLE;
        end else if (sts.key_hit) begin
          cmd.stage_char = 1'b1;
          state_nxt      = ST_EMIT;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          if (sts.stage_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/g2u_dp.sv
// datapath of the gb2312 to utf-8 converter: code table, search, stream state, output
`timescale 1ns / 1ps
`default_nettype none
module g2u_dp
  import g2u_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_opcode,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [CODE_W-1:0] in_entry_gb_code,
  input  wire logic [CODE_W-1:0] in_entry_unicode,
  input  wire logic [BYTE_W-1:0] in_text_byte,
  input  wire g2u_cmd_t          cmd,
  output g2u_sts_t               sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_last_of_run,
  output logic                   out_is_terminator,
  output logic [CNT_W-1:0]       out_output_length
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > NENT_W) ? CW : NENT_W;

  // configuration
  logic [MAXL_W-1:0] max_len_r;
  logic [NENT_W-1:0] nent_r;

  // code table
  logic [ENTRY_W-1:0] table_r [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_r;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_ok;

  // search
  logic [CODE_W-1:0] gb_r;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hx_r, hx_nxt;
  logic [AW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     n_clamp;
  logic [XW-1:0]     nent_x;
  logic [CW-1:0]     lo_step, hx_step;
  logic [CW:0]       sum_m1;
  logic [CODE_W-1:0] key;
  logic [CODE_W-1:0] cp;

  // stream state
  logic [BYTE_W-1:0] held_r;
  logic              lead_r;
  logic [CNT_W-1:0]  cnt_r;

  // staged result bytes
  logic [BYTE_W-1:0] st_b0_r, st_b1_r, st_b2_r;
  logic [1:0]        st_left_r;
  logic              st_term_r;
  logic [CNT_W-1:0]  st_len_r;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_term_r;
  logic [CNT_W-1:0]  out_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
      nent_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_LEN:       max_len_r <= cfg_wdata[MAXL_W-1:0];
        REG_TABLE_ENTRIES: nent_r    <= cfg_wdata[NENT_W-1:0];
        default: ;
      endcase
    end
  end

  assign wr_ok   = (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(in_entry_index);

  always_ff @(posedge clk) begin
    if (cmd.load_entry && wr_ok) begin
      table_r[wr_addr] <= {in_entry_gb_code, in_entry_unicode};
    end
    rd_r <= table_r[rd_addr];
  end

  assign key = rd_r[ENTRY_W-1:CODE_W];
  assign cp  = rd_r[CODE_W-1:0];

  always_comb begin
    nent_x  = XW'(nent_r);
    n_clamp = (nent_x > XW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(nent_x);
    if (key > gb_r) begin
      lo_step = lo_r;
      hx_step = CW'(mid_r);
    end else begin
      lo_step = CW'(mid_r) + CW'(1);
      hx_step = hx_r;
    end
    if (cmd.start_search) begin
      lo_nxt = '0;
      hx_nxt = n_clamp;
    end else if (cmd.search_step) begin
      lo_nxt = lo_step;
      hx_nxt = hx_step;
    end else begin
      lo_nxt = lo_r;
      hx_nxt = hx_r;
    end
    // midpoint of the closed range lo .. hx-1
    sum_m1  = (CW + 1)'(lo_nxt) + (CW + 1)'(hx_nxt) - (CW + 1)'(1);
    mid_nxt = AW'(sum_m1 >> 1);
    rd_addr = mid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      gb_r <= {held_r, in_text_byte};
    end
    lo_r  <= lo_nxt;
    hx_r  <= hx_nxt;
    mid_r <= mid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      lead_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cmd.stage_term) begin
        held_r <= '0;
        lead_r <= 1'b0;
        cnt_r  <= '0;
      end else if (cmd.start_search) begin
        held_r <= '0;
        lead_r <= 1'b0;
      end else if (cmd.hold_lead) begin
        held_r <= in_text_byte;
        lead_r <= 1'b1;
      end else if (cmd.stage_ascii) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.stage_char) begin
        cnt_r <= cnt_r + CNT_W'(3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_left_r <= '0;
    end else begin
      if (cmd.stage_term) begin
        st_b0_r   <= '0;
        st_left_r <= 2'd1;
        st_term_r <= 1'b1;
        st_len_r  <= cnt_r;
      end else if (cmd.stage_ascii) begin
        st_b0_r   <= in_text_byte;
        st_left_r <= 2'd1;
        st_term_r <= 1'b0;
        st_len_r  <= '0;
      end else if (cmd.stage_char) begin
        st_b0_r   <= UTF8_LEAD3 | {4'b0, cp[15:12]};
        st_b1_r   <= UTF8_CONT | {2'b0, cp[11:6]};
        st_b2_r   <= UTF8_CONT | {2'b0, cp[5:0]};
        st_left_r <= 2'd3;
        st_term_r <= 1'b0;
        st_len_r  <= '0;
      end else if (cmd.push) begin
        st_b0_r   <= st_b1_r;
        st_b1_r   <= st_b2_r;
        st_left_r <= st_left_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_byte_r <= st_b0_r;
      out_last_r <= (st_left_r == 2'd1);
      out_term_r <= st_term_r;
      out_len_r  <= st_len_r;
    end
  end

  always_comb begin
    sts.op_text     = (in_opcode == OP_TEXT);
    sts.byte_zero   = (in_text_byte == '0);
    sts.byte_high   = in_text_byte[BYTE_W-1];
    sts.lead_held   = lead_r;
    sts.at_limit    = (cnt_r >= {1'b0, max_len_r});
    sts.range_empty = (lo_r >= hx_r);
    sts.key_hit     = (key == gb_r);
    sts.out_free    = !out_valid_r || out_ready;
    sts.stage_last  = (st_left_r == 2'd1);
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_run   = out_last_r;
  assign out_is_terminator = out_term_r;
  assign out_output_length = out_len_r;

endmodule
`default_nettype wire

>>> rtl/gb2312_to_utf8_converter.sv
// top level of the gb2312 to utf-8 converter
// ascii byte or terminator: staged in the staging registers when its request is accepted, then
// moved into the output register once that register is free
// double-byte character: up to ceil(log2(n+1)) table probes, one probe per cycle through
// the registered table read port, then its three utf-8 bytes are pushed through the output register
// load requests and dropped bytes are done in the idle state; one request at a time
// synchronous active-low reset resets control, stream state and config; the table is not cleared
`timescale 1ns / 1ps
`default_nettype none
module gb2312_to_utf8_converter
  import g2u_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_opcode,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [CODE_W-1:0] in_entry_gb_code,
  input  wire logic [CODE_W-1:0] in_entry_unicode,
  input  wire logic [BYTE_W-1:0] in_text_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_last_of_run,
  output logic                   out_is_terminator,
  output logic [CNT_W-1:0]       out_output_length
);

  g2u_cmd_t cmd;
  g2u_sts_t sts;

  g2u_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  g2u_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_entry_gb_code  (in_entry_gb_code),
    .in_entry_unicode  (in_entry_unicode),
    .in_text_byte      (in_text_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_is_terminator (out_is_terminator),
    .out_output_length (out_output_length)
  );

endmodule
`default_nettype wire

>>> rtl/g2u_checker.sv
// port-level assertions of the gb2312 to utf-8 converter and their bind
`timescale 1ns / 1ps
`default_nettype none
module g2u_checker
  import g2u_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_opcode,
  input wire logic [BYTE_W-1:0] in_text_byte,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic              out_last_of_run,
  input wire logic              out_is_terminator,
  input wire logic [CNT_W-1:0]  out_output_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  a_term_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_terminator |-> out_byte == '0 && out_last_of_run)
    else $error("terminator not a closing zero");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_terminator |-> out_output_length == '0)
    else $error("length on a non-terminator result");

  a_term_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_TEXT && in_text_byte == '0 |=> !in_ready)
    else $error("request taken while terminator pending");

endmodule

bind gb2312_to_utf8_converter g2u_checker u_g2u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_opcode         (in_opcode),
  .in_text_byte      (in_text_byte),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_byte          (out_byte),
  .out_last_of_run   (out_last_of_run),
  .out_is_terminator (out_is_terminator),
  .out_output_length (out_output_length)
);
`default_nettype wire

>>> bench/testbench.sv
// testbench for the gb2312 to utf-8 converter: directed steps, then random text checked by a predictor
`timescale 1ns / 1ps
module testbench;
  import g2u_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int FILL = 63;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] gb;
    logic [CODE_W-1:0] cp;
    logic [BYTE_W-1:0] txt;
  } request_t;

  typedef struct packed {
    logic [BYTE_W-1:0] val;
    logic              last;
    logic              term;
    logic [CNT_W-1:0]  len;
  } utf8_byte_t;

  typedef struct {
    bit                is_cfg;
    logic              sel;
    logic [CFG_W-1:0]  wval;
    request_t          r;
    bit                typed;
    bit                n_typed;
    logic [BYTE_W-1:0] eb;
    logic [CNT_W-1:0]  el;
  } step_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_opcode = 1'b0;
  logic [IDX_W-1:0]  in_entry_index = '0;
  logic [CODE_W-1:0] in_entry_gb_code = '0;
  logic [CODE_W-1:0] in_entry_unicode = '0;
  logic [BYTE_W-1:0] in_text_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last_of_run;
  logic              out_is_terminator;
  logic [CNT_W-1:0]  out_output_length;

  // predictor state
  logic [ENTRY_W-1:0] code_mem [DEPTH];
  logic [BYTE_W-1:0]  lead_byte = '0;
  logic               lead_valid = 1'b0;
  logic [CNT_W-1:0]   out_count = '0;
  logic [MAXL_W-1:0]  max_len = MAX_LEN_RST;
  logic [NENT_W-1:0]  num_entries = '0;
  utf8_byte_t         pred_out [3];

  utf8_byte_t expected_bytes [$];
  step_t      plan [$];
  int         snd_idle = 30;
  int         rcv_idle = 70;
  int         fail_count = 0;
  int         stall_cycles = 0;

  gb2312_to_utf8_converter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_entry_gb_code  (in_entry_gb_code),
    .in_entry_unicode  (in_entry_unicode),
    .in_text_byte      (in_text_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_is_terminator (out_is_terminator),
    .out_output_length (out_output_length)
  );

  always #5 clk = ~clk;

  function automatic request_t text_req(logic [BYTE_W-1:0] b);
    request_t r;
    r = '{OP_TEXT, '0, '0, '0, b};
    return r;
  endfunction

  function automatic request_t load_req(logic [IDX_W-1:0] idx, logic [CODE_W-1:0] gb,
                                        logic [CODE_W-1:0] cp);
    request_t r;
    r = '{OP_LOAD, idx, gb, cp, '0};
    return r;
  endfunction

  function automatic step_t plan_step(bit is_cfg, logic sel, logic [CFG_W-1:0] wval,
                                      request_t r, bit typed, bit n_typed,
                                      logic [BYTE_W-1:0] eb, logic [CNT_W-1:0] el);
    step_t s;
    s.is_cfg = is_cfg;
    s.sel = sel;
    s.wval = wval;
    s.r = r;
    s.typed = typed;
    s.n_typed = n_typed;
    s.eb = eb;
    s.el = el;
    return s;
  endfunction

  // returns the number of utf-8 bytes placed in pred_out
  function automatic int transcode(request_t r);
    int lo, hi, mid, n;
    logic [CODE_W-1:0] gb, cp, key;
    bit hit;
    if (r.op == OP_LOAD) begin
      code_mem[r.idx] = {r.gb, r.cp};
      return 0;
    end
    if (r.txt == '0) begin
      pred_out[0] = '{8'h00, 1'b1, 1'b1, out_count};
      lead_byte = '0;
      lead_valid = 1'b0;
      out_count = '0;
      return 1;
    end
    if (lead_valid) begin
      gb = {lead_byte, r.txt};
      lead_byte = '0;
      lead_valid = 1'b0;
      n = (num_entries > DEPTH) ? DEPTH : int'(num_entries);
      lo = 0;
      hi = n - 1;
      hit = 1'b0;
      cp = '0;
      while (!hit && lo <= hi) begin
        mid = (lo + hi) / 2;
        key = code_mem[mid][ENTRY_W-1:CODE_W];
        if (key == gb) begin
          hit = 1'b1;
          cp = code_mem[mid][CODE_W-1:0];
        end else if (key > gb) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
      if (!hit) return 0;
      pred_out[0] = '{UTF8_LEAD3 | {4'h0, cp[15:12]}, 1'b0, 1'b0, '0};
      pred_out[1] = '{UTF8_CONT | {2'b00, cp[11:6]}, 1'b0, 1'b0, '0};
      pred_out[2] = '{UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, '0};
      out_count = out_count + CNT_W'(3);
      return 3;
    end
    if (out_count >= {1'b0, max_len}) return 0;
    if (r.txt[7]) begin
      lead_byte = r.txt;
      lead_valid = 1'b1;
      return 0;
    end
    pred_out[0] = '{r.txt, 1'b1, 1'b0, '0};
    out_count = out_count + CNT_W'(1);
    return 1;
  endfunction

  task automatic issue(request_t r, bit typed = 1'b0, bit n_typed = 1'b0,
                       logic [BYTE_W-1:0] eb = '0, logic [CNT_W-1:0] el = '0);
    int n;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid <= 1'b1;
    in_opcode <= r.op;
    in_entry_index <= r.idx;
    in_entry_gb_code <= r.gb;
    in_entry_unicode <= r.cp;
    in_text_byte <= r.txt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = transcode(r);
    if (typed) begin
      if (n_typed) expected_bytes.push_back({eb, 1'b1, (eb == '0), el});
    end else begin
      for (int k = 0; k < n; k++) expected_bytes.push_back(pred_out[k]);
    end
  endtask

  // sender holds off until every expected byte is out, then waits out the latency
  task automatic settle(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_MAX_LEN) max_len = val[MAXL_W-1:0];
    else num_entries = val[NENT_W-1:0];
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    utf8_byte_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %h", out_byte);
        fail_count++;
      end else begin
        e = expected_bytes.pop_front();
        if (out_byte !== e.val) begin
          $error("out_byte: expected %h, got %h", e.val, out_byte);
          fail_count++;
        end
        if (out_last_of_run !== e.last) begin
          $error("out_last_of_run: expected %b, got %b", e.last, out_last_of_run);
          fail_count++;
        end
        if (out_is_terminator !== e.term) begin
          $error("out_is_terminator: expected %b, got %b", e.term, out_is_terminator);
          fail_count++;
        end
        if (out_output_length !== e.len) begin
          $error("out_output_length: expected %0d, got %0d", e.len, out_output_length);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [CODE_W-1:0] key;
    int sent, slot, n_eff, pick, mode;

    // empty table, reset limit
    plan.push_back(plan_step(0, 0, 0, text_req(8'h41), 1, 1, 8'h41, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h7F), 1, 1, 8'h7F, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h80), 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'hA1), 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h00), 1, 1, 8'h00, 2));
    plan.push_back(plan_step(0, 0, 0, text_req(8'hFF), 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h00), 1, 1, 8'h00, 0));
    // small sorted table
    plan.push_back(plan_step(0, 0, 0, load_req(0, 16'h8141, 16'h0000), 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, load_req(1, 16'hB0A1, 16'h554A), 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, load_req(2, 16'hC0C0, 16'h07FF), 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, load_req(3, 16'hD6D0, 16'h4E2D), 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, load_req(4, 16'hFEFE, 16'hFFFF), 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, load_req(5, 16'hFFFF, 16'h8000), 1, 0, 0, 0));
    plan.push_back(plan_step(1, REG_TABLE_ENTRIES, 16'd6, '0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h81), 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h41), 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'hFE), 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'hFE), 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'hC0), 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'hC0), 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h00), 1, 1, 8'h00, 9));
    // output limit of one byte
    plan.push_back(plan_step(1, REG_MAX_LEN, 16'd1, '0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h42), 1, 1, 8'h42, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h43), 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'hD6), 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h00), 1, 1, 8'h00, 1));
    plan.push_back(plan_step(0, 0, 0, text_req(8'hD6), 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'hD0), 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, text_req(8'h00), 1, 1, 8'h00, 3));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle(24);
        write_reg(plan[i].sel, plan[i].wval);
      end else begin
        issue(plan[i].r, plan[i].typed, plan[i].n_typed, plan[i].eb, plan[i].el);
      end
    end

    // low slots in ascending order, top keys on the slots a full-depth search probes first,
    // so a search with any entry count that this bench sets only reads written slots
    settle(24);
    snd_idle = 0;
    rcv_idle = 0;
    for (int i = 0; i < FILL; i++)
      issue(load_req(IDX_W'(i), CODE_W'(16'h8001 + 4 * i), CODE_W'($urandom)));
    for (int s = 6; s < 13; s++)
      issue(load_req(IDX_W'((1 << s) - 1), 16'hFFFF, CODE_W'($urandom)));

    for (int seg = 0; seg < 6; seg++) begin
      settle(24);
      case (seg)
        0: begin
          write_reg(REG_MAX_LEN, 16'hFFFF);
          write_reg(REG_TABLE_ENTRIES, 16'd8192);
        end
        1: begin
          write_reg(REG_MAX_LEN, 16'd9);
          write_reg(REG_TABLE_ENTRIES, 16'h3FFF);
        end
        2: begin
          write_reg(REG_MAX_LEN, 16'd30);
          write_reg(REG_TABLE_ENTRIES, 16'd1);
        end
        3: begin
          write_reg(REG_MAX_LEN, CFG_W'($urandom_range(1, 40)));
          write_reg(REG_TABLE_ENTRIES, CFG_W'($urandom_range(1, FILL)));
        end
        4: begin
          write_reg(REG_MAX_LEN, 16'd2);
          write_reg(REG_TABLE_ENTRIES, 16'd0);
        end
        default: begin
          write_reg(REG_MAX_LEN, 16'hFFFF);
          write_reg(REG_TABLE_ENTRIES, 16'd6);
        end
      endcase
      mode = seg / 2;
      snd_idle = (mode == 0) ? 30 : (mode == 1) ? 70 : 0;
      rcv_idle = (mode == 0) ? 70 : (mode == 1) ? 30 : 0;

      sent = 0;
      while (sent < 52) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          slot = $urandom_range(FILL - 1);
          key = ($urandom_range(3) != 0) ? code_mem[slot][ENTRY_W-1:CODE_W]
                                         : CODE_W'($urandom);
          issue(load_req(IDX_W'(slot), key, CODE_W'($urandom)));
          sent++;
        end else if (pick < 55 || (pick >= 70 && pick < 78)) begin
          if (pick < 55) begin
            n_eff = (num_entries > DEPTH) ? DEPTH : int'(num_entries);
            if (n_eff == 0 || n_eff > FILL) n_eff = FILL;
            slot = $urandom_range(n_eff - 1);
            key = code_mem[slot][ENTRY_W-1:CODE_W];
          end else begin
            key = CODE_W'($urandom);
          end
          if (!key[15] || key[7:0] == '0)
            key = {1'b1, 7'($urandom), 8'($urandom_range(1, 255))};
          issue(text_req(key[15:8]));
          issue(text_req(key[7:0]));
          sent += 2;
        end else if (pick < 70) begin
          issue(text_req(BYTE_W'($urandom_range(1, 127))));
          sent++;
        end else if (pick < 87) begin
          issue(text_req('0));
          sent++;
        end else if (pick < 95) begin
          issue(text_req(BYTE_W'($urandom_range(1, 255))));
          sent++;
        end else if (pick < 97) begin
          settle(0);
        end else begin
          issue(text_req(BYTE_W'($urandom_range(128, 255))));
          issue(text_req('0));
          sent += 2;
        end
      end
    end

    settle(30);
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
